// ===== sv/i2cbb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbb_pkg
// Types and constants shared by the tick-driven I2C bit-bang master.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_ST0  = 5'd1,
    PH_ST1  = 5'd2,
    PH_ST2  = 5'd3,
    PH_ST3  = 5'd4,
    PH_TXD  = 5'd5,
    PH_TXH  = 5'd6,
    PH_TXL  = 5'd7,
    PH_AK0  = 5'd8,
    PH_AK1  = 5'd9,
    PH_AK2  = 5'd10,
    PH_RXR  = 5'd11,
    PH_RXH  = 5'd12,
    PH_RXL  = 5'd13,
    PH_MA0  = 5'd14,
    PH_MA1  = 5'd15,
    PH_MA2  = 5'd16,
    PH_SP0  = 5'd17,
    PH_SP1  = 5'd18,
    PH_SP2  = 5'd19,
    PH_SP3  = 5'd20,
    PH_SP4  = 5'd21
  } phase_t;

  localparam logic [2:0] KIND_PTR_STOP = 3'd0;
  localparam logic [2:0] KIND_PTR_NOSTOP = 3'd1;
  localparam logic [2:0] KIND_WR8 = 3'd2;
  localparam logic [2:0] KIND_WR16 = 3'd3;

  localparam int BITS_PER_BYTE = 8;

  typedef struct packed {
    logic        cmd_valid;
    logic [2:0]  kind;
    logic [6:0]  dev_addr;
    logic [7:0]  reg_addr;
    logic [15:0] wdata;
    logic        sda_in;
  } cmd_t;

  typedef struct packed {
    logic        scl;
    logic        sda;
    logic        busy_res;
    logic        done_res;
    logic        ok;
    logic [63:0] rdata;
  } res_t;

endpackage

// ===== sv/i2cbb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbb_cmd_if / i2cbb_res_if
// Valid/ready channels for tick items and pin update results.
// ----------------------------------------------------------------------------
interface i2cbb_cmd_if import i2cbb_pkg::*;;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cbb_res_if import i2cbb_pkg::*;;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/i2cbb_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbb_core
// Bus sequencer: one pin action per tick, state advanced on each step.
// ----------------------------------------------------------------------------
module i2cbb_core import i2cbb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  cmd_t cmd,
  output res_t res_nxt,
  output logic idle
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  bit_cnt_r, bit_cnt_nxt;
  logic [3:0]  byte_cnt_r, byte_cnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [63:0] accum_r, accum_nxt;
  logic        ok_r, ok_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic [7:0]  reg_lat_r, reg_lat_nxt;
  logic [15:0] data_lat_r, data_lat_nxt;

  logic [3:0] byte_inc;
  logic [3:0] bit_inc;
  logic [3:0] rd_total;
  logic       rd_last;
  logic       busy;
  logic       done;

  assign idle     = (phase_r == PH_IDLE);
  assign byte_inc = byte_cnt_r + 4'd1;
  assign bit_inc  = bit_cnt_r + 4'd1;
  assign rd_total = 4'd1 << kind_r[1:0];
  assign rd_last  = (byte_cnt_r >= rd_total);

  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    shift_nxt    = shift_r;
    kind_nxt     = kind_r;
    accum_nxt    = accum_r;
    ok_nxt       = ok_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    reg_lat_nxt  = reg_lat_r;
    data_lat_nxt = data_lat_r;
    busy         = 1'b0;
    done         = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (cmd.cmd_valid) begin
        // start accepted: latch command and perform the first start action
        busy         = 1'b1;
        kind_nxt     = cmd.kind;
        reg_lat_nxt  = cmd.reg_addr;
        data_lat_nxt = cmd.wdata;
        shift_nxt    = {cmd.dev_addr, cmd.kind[2]};
        bit_cnt_nxt  = 4'd0;
        byte_cnt_nxt = 4'd0;
        accum_nxt    = '0;
        ok_nxt       = 1'b1;
        sda_nxt      = 1'b1;
        phase_nxt    = PH_ST1;
      end
    end else begin
      busy = 1'b1;
      unique case (phase_r)
        PH_ST0: begin
          sda_nxt   = 1'b1;
          phase_nxt = PH_ST1;
        end
        PH_ST1: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_ST2;
        end
        PH_ST2: begin
          sda_nxt   = 1'b0;
          phase_nxt = PH_ST3;
        end
        PH_ST3: begin
          scl_nxt      = 1'b0;
          byte_cnt_nxt = 4'd0;
          bit_cnt_nxt  = 4'd0;
          phase_nxt    = PH_TXD;
        end
        PH_TXD: begin
          sda_nxt   = shift_r[BITS_PER_BYTE-1];
          phase_nxt = PH_TXH;
        end
        PH_TXH: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_TXL;
        end
        PH_TXL: begin
          scl_nxt     = 1'b0;
          shift_nxt   = {shift_r[6:0], 1'b0};
          bit_cnt_nxt = bit_inc;
          phase_nxt   = (bit_inc >= 4'(BITS_PER_BYTE)) ? PH_AK0 : PH_TXD;
        end
        PH_AK0: begin
          sda_nxt   = 1'b1;
          phase_nxt = PH_AK1;
        end
        PH_AK1: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_AK2;
        end
        PH_AK2: begin
          scl_nxt = 1'b0;
          if (cmd.sda_in) begin
            ok_nxt    = 1'b0;
            phase_nxt = PH_SP0;
          end else if (kind_r[2]) begin
            byte_cnt_nxt = 4'd0;
            bit_cnt_nxt  = 4'd0;
            phase_nxt    = PH_RXR;
          end else begin
            byte_cnt_nxt = byte_inc;
            phase_nxt    = PH_SP0;
            if (byte_inc == 4'd1) begin
              shift_nxt   = reg_lat_r;
              bit_cnt_nxt = 4'd0;
              phase_nxt   = PH_TXD;
            end else if (byte_inc == 4'd2) begin
              case (kind_r)
                KIND_PTR_STOP: phase_nxt = PH_SP0;
                KIND_PTR_NOSTOP: begin
                  phase_nxt = PH_IDLE;
                  done      = 1'b1;
                end
                KIND_WR8: begin
                  shift_nxt   = data_lat_r[7:0];
                  bit_cnt_nxt = 4'd0;
                  phase_nxt   = PH_TXD;
                end
                default: begin
                  shift_nxt   = data_lat_r[15:8];
                  bit_cnt_nxt = 4'd0;
                  phase_nxt   = PH_TXD;
                end
              endcase
            end else if (byte_inc == 4'd3 && kind_r == KIND_WR16) begin
              shift_nxt   = data_lat_r[7:0];
              bit_cnt_nxt = 4'd0;
              phase_nxt   = PH_TXD;
            end
          end
        end
        PH_RXR: begin
          sda_nxt   = 1'b1;
          phase_nxt = PH_RXH;
        end
        PH_RXH: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_RXL;
        end
        PH_RXL: begin
          scl_nxt     = 1'b0;
          accum_nxt   = {accum_r[62:0], cmd.sda_in};
          bit_cnt_nxt = bit_inc;
          if (bit_inc >= 4'(BITS_PER_BYTE)) begin
            byte_cnt_nxt = byte_inc;
            phase_nxt    = PH_MA0;
          end else begin
            phase_nxt = PH_RXH;
          end
        end
        PH_MA0: begin
          sda_nxt   = rd_last;
          phase_nxt = PH_MA1;
        end
        PH_MA1: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_MA2;
        end
        PH_MA2: begin
          scl_nxt = 1'b0;
          if (rd_last) begin
            phase_nxt = PH_SP0;
          end else begin
            bit_cnt_nxt = 4'd0;
            phase_nxt   = PH_RXR;
          end
        end
        PH_SP0: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_SP1;
        end
        PH_SP1: begin
          sda_nxt   = 1'b0;
          phase_nxt = PH_SP2;
        end
        PH_SP2: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_SP3;
        end
        PH_SP3: begin
          sda_nxt   = 1'b1;
          phase_nxt = PH_SP4;
        end
        PH_SP4: begin
          sda_nxt   = 1'b1;
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    res_nxt.scl      = scl_nxt;
    res_nxt.sda      = sda_nxt;
    res_nxt.busy_res = busy;
    res_nxt.done_res = done;
    res_nxt.ok       = ok_nxt;
    res_nxt.rdata    = accum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bit_cnt_r  <= 4'd0;
      byte_cnt_r <= 4'd0;
      kind_r     <= 3'd0;
      accum_r    <= '0;
      ok_r       <= 1'b1;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
    end else if (step) begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      kind_r     <= kind_nxt;
      accum_r    <= accum_nxt;
      ok_r       <= ok_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      shift_r    <= shift_nxt;
      reg_lat_r  <= reg_lat_nxt;
      data_lat_r <= data_lat_nxt;
    end
  end

endmodule

// ===== sv/i2c_bitbang_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bitbang_master
// Tick-driven I2C master: each tick transfer yields one pin update transfer.
// ----------------------------------------------------------------------------
// Every tick transfer on in_ch advances the bus sequence by one pin action and
// produces exactly one result transfer on out_ch, registered and offered in the
// following cycle. One tick is taken per clock while out_ch.ready stays high;
// the rate is set by the single state update of the sequencer. A new tick
// enters in the same cycle that the previous result is taken, so ticks flow
// back to back while out_ch.ready stays high; while a result waits for
// out_ch.ready, in_ch.ready is held low. A command is started by a tick with
// cmd_valid high while no transaction is running; ticks that arrive during a
// transaction ignore the command fields and only supply the sampled SDA level.
module i2c_bitbang_master import i2cbb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  i2cbb_cmd_if.sink    in_ch,
  i2cbb_res_if.source  out_ch
);

  logic in_xfer;
  logic core_idle;
  res_t res_nxt;
  res_t out_data_r;
  logic out_valid_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  i2cbb_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_xfer),
    .cmd     (in_ch.data),
    .res_nxt (res_nxt),
    .idle    (core_idle)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

`ifndef SYNTHESIS
  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && core_idle && in_ch.data.cmd_valid |=>
      out_valid_r && out_data_r.busy_res && out_data_r.ok && !out_data_r.done_res
      && (out_data_r.rdata == 64'd0))
    else $error("start transfer did not produce a fresh busy result");

  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && core_idle && !in_ch.data.cmd_valid |=>
      out_valid_r && !out_data_r.busy_res && !out_data_r.done_res)
    else $error("idle tick reported activity");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !core_idle |=> out_data_r.busy_res && (core_idle || !out_data_r.done_res))
    else $error("done and sequencer state disagree");
`endif

endmodule

// ===== test/i2cbb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbb_checker
// Watches the tick and pin update channels of the I2C bit-bang master. Every
// accepted tick is run through a cycle-exact model of the bus sequencer, and
// each pin update transfer is compared field by field with the oldest
// predicted update.
// ----------------------------------------------------------------------------
module i2cbb_checker import i2cbb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  i2cbb_cmd_if  tick_bus,
  i2cbb_res_if  pin_bus,
  output int    fail_count,
  output int    pending
);

  // sequencer model state
  phase_t      ph;
  logic [3:0]  bit_cnt;
  logic [3:0]  byte_cnt;
  logic [7:0]  shreg;
  logic [2:0]  act_kind;
  logic [63:0] rd_acc;
  logic        ok_q;
  logic        scl_q;
  logic        sda_q;
  logic [7:0]  lat_reg;
  logic [15:0] lat_data;

  res_t pin_updates_q[$];
  res_t want;
  res_t got;
  int   errors;
  int   update_count;

  assign fail_count = errors;

  task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
    $display("%0t: pin update %0d: %s got %0h expected %0h",
             $time, update_count, what, got_v, want_v);
    errors++;
  endtask

  task automatic load_tx_byte(input logic [7:0] b);
    shreg = b;
    bit_cnt = '0;
    ph = PH_TXD;
  endtask

  // what follows an acknowledged byte; fin set when the transaction ends here
  task automatic next_after_ack(output logic fin);
    fin = 1'b0;
    byte_cnt = byte_cnt + 4'd1;
    if (act_kind > KIND_WR16) begin
      byte_cnt = '0;
      bit_cnt = '0;
      ph = PH_RXR;
    end else if (byte_cnt == 4'd1) begin
      load_tx_byte(lat_reg);
    end else if (byte_cnt == 4'd2) begin
      case (act_kind)
        KIND_PTR_STOP: ph = PH_SP0;
        KIND_PTR_NOSTOP: begin
          ph = PH_IDLE;
          fin = 1'b1;
        end
        KIND_WR8: load_tx_byte(lat_data[7:0]);
        default: load_tx_byte(lat_data[15:8]);
      endcase
    end else if (byte_cnt == 4'd3 && act_kind == KIND_WR16) begin
      load_tx_byte(lat_data[7:0]);
    end else begin
      ph = PH_SP0;
    end
  endtask

  task automatic predict_pin_update(input cmd_t t, output res_t r);
    logic fin;
    logic last_rx;
    fin = 1'b0;
    r.busy_res = 1'b0;
    if (ph == PH_IDLE && t.cmd_valid) begin
      act_kind = t.kind;
      lat_reg = t.reg_addr;
      lat_data = t.wdata;
      shreg = {t.dev_addr, t.kind > KIND_WR16};
      bit_cnt = '0;
      byte_cnt = '0;
      rd_acc = '0;
      ok_q = 1'b1;
      ph = PH_ST0;
    end
    last_rx = int'(byte_cnt) >= (1 << act_kind[1:0]);
    if (ph != PH_IDLE) begin
      r.busy_res = 1'b1;
      case (ph)
        PH_ST0: begin
          sda_q = 1'b1;
          ph = PH_ST1;
        end
        PH_ST1: begin
          scl_q = 1'b1;
          ph = PH_ST2;
        end
        PH_ST2: begin
          sda_q = 1'b0;
          ph = PH_ST3;
        end
        PH_ST3: begin
          scl_q = 1'b0;
          byte_cnt = '0;
          bit_cnt = '0;
          ph = PH_TXD;
        end
        PH_TXD: begin
          sda_q = shreg[7];
          ph = PH_TXH;
        end
        PH_TXH: begin
          scl_q = 1'b1;
          ph = PH_TXL;
        end
        PH_TXL: begin
          scl_q = 1'b0;
          shreg = {shreg[6:0], 1'b0};
          bit_cnt = bit_cnt + 4'd1;
          ph = (bit_cnt >= 4'd8) ? PH_AK0 : PH_TXD;
        end
        PH_AK0: begin
          sda_q = 1'b1;
          ph = PH_AK1;
        end
        PH_AK1: begin
          scl_q = 1'b1;
          ph = PH_AK2;
        end
        PH_AK2: begin
          scl_q = 1'b0;
          if (t.sda_in) begin
            ok_q = 1'b0;
            ph = PH_SP0;
          end else begin
            next_after_ack(fin);
          end
        end
        PH_RXR: begin
          sda_q = 1'b1;
          ph = PH_RXH;
        end
        PH_RXH: begin
          scl_q = 1'b1;
          ph = PH_RXL;
        end
        PH_RXL: begin
          scl_q = 1'b0;
          rd_acc = {rd_acc[62:0], t.sda_in};
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= 4'd8) begin
            byte_cnt = byte_cnt + 4'd1;
            ph = PH_MA0;
          end else begin
            ph = PH_RXH;
          end
        end
        PH_MA0: begin
          // nack only the last byte
          sda_q = last_rx;
          ph = PH_MA1;
        end
        PH_MA1: begin
          scl_q = 1'b1;
          ph = PH_MA2;
        end
        PH_MA2: begin
          scl_q = 1'b0;
          if (last_rx) begin
            ph = PH_SP0;
          end else begin
            bit_cnt = '0;
            ph = PH_RXR;
          end
        end
        PH_SP0: begin
          scl_q = 1'b0;
          ph = PH_SP1;
        end
        PH_SP1: begin
          sda_q = 1'b0;
          ph = PH_SP2;
        end
        PH_SP2: begin
          scl_q = 1'b1;
          ph = PH_SP3;
        end
        PH_SP3: begin
          sda_q = 1'b1;
          ph = PH_SP4;
        end
        PH_SP4: begin
          sda_q = 1'b1;
          ph = PH_IDLE;
          fin = 1'b1;
        end
        default: ph = PH_IDLE;
      endcase
    end
    r.scl = scl_q;
    r.sda = sda_q;
    r.done_res = fin;
    r.ok = ok_q;
    r.rdata = rd_acc;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ph = PH_IDLE;
      bit_cnt = '0;
      byte_cnt = '0;
      shreg = '0;
      act_kind = '0;
      rd_acc = '0;
      ok_q = 1'b1;
      scl_q = 1'b1;
      sda_q = 1'b1;
      lat_reg = '0;
      lat_data = '0;
      pin_updates_q.delete();
    end else begin
      if (tick_bus.valid && tick_bus.ready) begin
        predict_pin_update(tick_bus.data, want);
        pin_updates_q.push_back(want);
      end
      if (pin_bus.valid && pin_bus.ready) begin
        got = pin_bus.data;
        if (pin_updates_q.size() == 0) begin
          report_mismatch("transfer with no tick waiting", '0, '0);
        end else begin
          want = pin_updates_q.pop_front();
          if (got.scl !== want.scl) report_mismatch("scl", 64'(got.scl), 64'(want.scl));
          if (got.sda !== want.sda) report_mismatch("sda", 64'(got.sda), 64'(want.sda));
          if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", 64'(got.busy_res), 64'(want.busy_res));
          if (got.done_res !== want.done_res)
            report_mismatch("done_res", 64'(got.done_res), 64'(want.done_res));
          if (got.ok !== want.ok) report_mismatch("ok", 64'(got.ok), 64'(want.ok));
          if (got.rdata !== want.rdata) report_mismatch("rdata", got.rdata, want.rdata);
        end
        update_count++;
      end
    end
    pending <= pin_updates_q.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the I2C bit-bang master with whole bus transactions: each one is a
// command tick followed by the exact number of ticks that its pin sequence
// takes, with ACK, NACK and read bits placed on the ticks that sample SDA.
// Both channels idle at random; the result side holds off once for a long
// stretch. The checker predicts and compares every pin update.
// ----------------------------------------------------------------------------
module tb;
  import i2cbb_pkg::*;

  localparam logic [2:0] KIND_RD8 = 3'd4;
  localparam logic [2:0] KIND_RD16 = 3'd5;
  localparam logic [2:0] KIND_RD32 = 3'd6;
  localparam logic [2:0] KIND_RD64 = 3'd7;

  localparam int RANDOM_TICKS = 215;
  localparam int HOLD_AT = 450;
  localparam int HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst_n;
  logic gaps_on;
  int   fail_count;
  int   pending;
  int   ticks_sent;
  int   results_seen;
  int   hold_left;
  logic hold_done;
  int   quiet_cycles;

  i2cbb_cmd_if tick_bus ();
  i2cbb_res_if pin_bus ();

  i2c_bitbang_master u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (tick_bus),
    .out_ch (pin_bus)
  );

  i2cbb_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_bus   (tick_bus),
    .pin_bus    (pin_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int tx_bytes(input logic [2:0] kind);
    case (kind)
      KIND_PTR_STOP, KIND_PTR_NOSTOP: return 2;
      KIND_WR8: return 3;
      KIND_WR16: return 4;
      default: return 1;
    endcase
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // tick with random command fields; only sda matters once a transaction runs
  function automatic cmd_t random_tick(input logic sda);
    cmd_t t;
    t.cmd_valid = 1'($urandom_range(0, 1));
    t.kind = 3'($urandom_range(0, 7));
    t.dev_addr = 7'($urandom_range(0, 127));
    t.reg_addr = 8'($urandom_range(0, 255));
    t.wdata = 16'($urandom_range(0, 65535));
    t.sda_in = sda;
    return t;
  endfunction

  task automatic drive_tick(input cmd_t t);
    while (gaps_on && $urandom_range(0, 99) < 19) begin
      tick_bus.valid <= 1'b0;
      @(posedge clk);
    end
    tick_bus.valid <= 1'b1;
    tick_bus.data <= t;
    @(posedge clk);
    while (!tick_bus.ready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic idle_tick();
    cmd_t t;
    t = random_tick(rand_bit());
    t.cmd_valid = 1'b0;
    drive_tick(t);
  endtask

  // one transaction; nack_slot picks the acknowledged byte that gets a nack
  task automatic run_txn(input logic [2:0] kind, input logic [6:0] dev,
                         input logic [7:0] reg_byte, input logic [15:0] wd,
                         input int nack_slot, input logic [63:0] rd_bits);
    cmd_t t;
    int   n_rx;
    int   b;
    int   i;
    t.cmd_valid = 1'b1;
    t.kind = kind;
    t.dev_addr = dev;
    t.reg_addr = reg_byte;
    t.wdata = wd;
    t.sda_in = rand_bit();
    drive_tick(t);
    repeat (3) drive_tick(random_tick(rand_bit()));
    for (b = 0; b < tx_bytes(kind); b++) begin
      repeat (26) drive_tick(random_tick(rand_bit()));
      drive_tick(random_tick(b == nack_slot));
      if (b == nack_slot) begin
        repeat (5) drive_tick(random_tick(rand_bit()));
        return;
      end
    end
    if (kind == KIND_PTR_NOSTOP) return;
    n_rx = (kind > KIND_WR16) ? (1 << kind[1:0]) : 0;
    for (b = 0; b < n_rx; b++) begin
      drive_tick(random_tick(rand_bit()));
      for (i = 0; i < 8; i++) begin
        drive_tick(random_tick(rand_bit()));
        drive_tick(random_tick(rd_bits[63 - 8 * b - i]));
      end
      repeat (3) drive_tick(random_tick(rand_bit()));
    end
    repeat (5) drive_tick(random_tick(rand_bit()));
  endtask

  // result side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      pin_bus.ready <= 1'b0;
      results_seen <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (pin_bus.valid && pin_bus.ready) results_seen <= results_seen + 1;
      if (hold_left != 0) begin
        pin_bus.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        pin_bus.ready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        pin_bus.ready <= !(gaps_on && $urandom_range(0, 99) < 19);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (tick_bus.valid && tick_bus.ready) || (pin_bus.valid && pin_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cmd_t       t;
    logic [2:0] kind;
    int         nack_slot;
    int         random_end;
    rst_n = 1'b0;
    gaps_on = 1'b1;
    tick_bus.valid = 1'b0;
    tick_bus.data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, every write and pointer kind plus two read sizes, nack on address and on data
    t = '1;
    t.cmd_valid = 1'b0;
    drive_tick(t);
    idle_tick();
    run_txn(KIND_PTR_STOP, 7'h00, 8'h00, 16'h0000, -1, '0);
    run_txn(KIND_PTR_NOSTOP, 7'h7F, 8'hFF, 16'hFFFF, -1, '0);
    run_txn(KIND_WR8, 7'h7F, 8'hFF, 16'hFFFF, -1, '0);
    run_txn(KIND_WR16, 7'h2A, 8'h55, 16'hFF00, -1, '0);
    run_txn(KIND_RD8, 7'h7F, 8'h00, 16'h0000, -1, '1);
    // back-to-back stretch
    gaps_on <= 1'b0;
    run_txn(KIND_RD64, 7'h3C, 8'hF0, 16'h8001, -1, 64'hA5C3_0FF0_9966_1E2D);
    gaps_on <= 1'b1;
    run_txn(KIND_RD64, 7'h01, 8'h80, 16'h00FF, 0, '1);
    run_txn(KIND_WR16, 7'h40, 8'h01, 16'hA55A, 3, '0);

    // random transactions
    random_end = ticks_sent + RANDOM_TICKS;
    while (ticks_sent < random_end) begin
      kind = 3'($urandom_range(0, 7));
      nack_slot = ($urandom_range(0, 3) == 0) ?
                  int'($urandom_range(0, tx_bytes(kind) - 1)) : -1;
      run_txn(kind, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
              16'($urandom_range(0, 65535)), nack_slot, {$urandom, $urandom});
      repeat ($urandom_range(0, 2)) idle_tick();
    end

    tick_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
